// File: rtl/core/sepa_pkg.sv
// Shared types, constants and the pattern address function for sprite evaluation.
package sepa_pkg;

   localparam int ENTRY_COUNT  = 64;
   localparam int LINE_SPRITES = 8;
   localparam int SEL_CAP      = (LINE_SPRITES < 8) ? LINE_SPRITES : 8;
   localparam int SCAN_CAP     = (ENTRY_COUNT < 64) ? ENTRY_COUNT : 64;
   localparam int IDX_W        = (SCAN_CAP > 1) ? $clog2(SCAN_CAP) : 1;
   localparam int SLOT_W       = (SEL_CAP > 1) ? $clog2(SEL_CAP) : 1;
   localparam int CNT_W        = $clog2(SEL_CAP + 1);
   localparam int ADDR_W       = 8;
   localparam int STORE_DEPTH  = 256;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;

   localparam logic [1:0] KIND_SET_PTR = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_EVAL    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TALL_SPRITES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SELECT = 1'd1;

   localparam logic [2:0] PALETTE_BASE = 3'd4;

   typedef enum logic [1:0] {
      OP_SET_PTR,
      OP_WRITE,
      OP_EVAL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [7:0] line;
   } cmd_type;

   typedef struct packed {
      logic tall;
      logic table_sel;
   } cfg_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  slot;
      logic [12:0] pattern_addr;
      logic [7:0]  x_start;
      logic [2:0]  palette_sel;
      logic        in_front;
      logic        mirror_h;
      logic        zero_possible;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    clearing;
      logic    rsp_valid;
      rsp_type rsp;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_FETCH,
      ST_XFETCH,
      ST_OUTPUT
   } st_type;

   // Low-plane address: table, tile, plane bit (zero), fine row.
   function automatic logic [12:0] pattern_address(input logic [7:0] tile,
                                                   input logic       vflip,
                                                   input logic [3:0] row,
                                                   input logic       tall,
                                                   input logic       table_sel);
      logic [2:0] fine;
      logic       table_bit;
      logic [7:0] tno;
      fine = row[2:0] ^ {3{vflip}};
      if (tall) begin
         table_bit = tile[0];
         tno       = {tile[7:1], row[3] ^ vflip};
      end else begin
         table_bit = table_sel;
         tno       = tile;
      end
      return {table_bit, tno, 1'b0, fine};
   endfunction

endpackage

// File: rtl/core/sepa_front.sv
// Front end: accepts request beats, decodes the kind and stages commands for the queue.
module sepa_front import sepa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_data_byte,
   input  logic [7:0]        req_line_number,
   input  logic              clearing,
   input  logic [QCNT_W-1:0] q_count,
   output logic              busy,
   output logic              push,
   output cmd_type           push_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   // Room must remain for the staged command and the one being taken.
   assign busy   = clearing || ((q_count + QCNT_W'(valid_ff)) >= QCNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      valid_in     = 1'b0;
      cmd_in       = cmd_ff;
      cmd_in.data  = req_data_byte;
      cmd_in.line  = req_line_number;
      if (accept) begin
         unique case (req_kind)
            KIND_SET_PTR: begin
               valid_in  = 1'b1;
               cmd_in.op = OP_SET_PTR;
            end
            KIND_WRITE: begin
               valid_in  = 1'b1;
               cmd_in.op = OP_WRITE;
            end
            KIND_EVAL: begin
               valid_in  = 1'b1;
               cmd_in.op = OP_EVAL;
            end
            default: begin
               // drop the unused kind
               valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign push     = valid_ff;
   assign push_cmd = cmd_ff;

endmodule

// File: rtl/core/sepa_cmdq.sv
// Short command queue between the front end and the evaluation engine.
module sepa_cmdq import sepa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmd_type           push_cmd,
   input  logic              pop,
   output cmd_type           pop_cmd,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign empty   = (count_ff == '0);
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(do_pop);
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/sepa_back.sv
// Back end: attribute store, pointer, line scan and per-sprite result generation.
module sepa_back import sepa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_empty,
   input  cmd_type         q_cmd,
   output logic            q_pop,
   output back_status_type status
);

   logic [7:0]        store [STORE_DEPTH];
   logic [7:0]        rd_data_a_ff, rd_data_b_ff;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic [7:0]        wr_data;
   logic              wr_en;

   st_type            state_ff, state_in;
   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;
   logic [7:0]        ptr_ff, ptr_in;
   logic [7:0]        line_ff, line_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              look_valid_ff, look_valid_in;
   logic [IDX_W-1:0]  look_idx_ff, look_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              over_ff, over_in;
   logic              zero_ff, zero_in;
   logic [SLOT_W-1:0] emit_ff, emit_in;
   logic [7:0]        tile_ff, tile_in;
   logic [7:0]        attr_ff, attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  sel_idx_ff [SEL_CAP];
   logic [3:0]        sel_row_ff [SEL_CAP];

   logic [8:0]        diff;
   logic              hit, take;
   logic [SLOT_W-1:0] next_emit;
   logic [3:0]        row;

   // Row of the looked-up entry relative to the line.
   assign diff = {1'b0, line_ff} - {1'b0, rd_data_a_ff};
   assign hit  = !diff[8] && (cfg.tall ? (diff[7:4] == 4'd0) : (diff[7:3] == 5'd0));
   assign take = look_valid_ff && hit && (count_ff < CNT_W'(SEL_CAP));
   assign next_emit = emit_ff + 1'b1;
   assign row  = sel_row_ff[emit_ff];

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      ptr_in        = ptr_ff;
      line_in       = line_ff;
      scan_idx_in   = scan_idx_ff;
      look_valid_in = 1'b0;
      look_idx_in   = look_idx_ff;
      count_in      = count_ff;
      over_in       = over_ff;
      zero_in       = zero_ff;
      emit_in       = emit_ff;
      tile_in       = tile_ff;
      attr_in       = attr_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = q_cmd.data;
      q_pop         = 1'b0;

      // Collect a hit from the previous lookup.
      if (look_valid_ff && hit) begin
         if (take) begin
            count_in = count_ff + 1'b1;
            if (look_idx_ff == '0) begin
               zero_in = 1'b1;
            end
         end else begin
            over_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = 8'd0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_SET_PTR: begin
                     ptr_in = q_cmd.data;
                  end
                  OP_WRITE: begin
                     wr_en = 1'b1;
                  end
                  OP_EVAL: begin
                     line_in     = q_cmd.line;
                     scan_idx_in = '0;
                     count_in    = '0;
                     over_in     = 1'b0;
                     zero_in     = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     ptr_in = ptr_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr_a     = ADDR_W'({scan_idx_ff, 2'b00});
            look_valid_in = 1'b1;
            look_idx_in   = scan_idx_ff;
            scan_idx_in   = scan_idx_ff + 1'b1;
            if (scan_idx_ff == IDX_W'(SCAN_CAP - 1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            emit_in = '0;
            if (count_in == '0) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.palette_sel   = PALETTE_BASE;
               rsp_in.last          = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_addr_a = ADDR_W'({sel_idx_ff[emit_ff], 2'b01});
            rd_addr_b = ADDR_W'({sel_idx_ff[emit_ff], 2'b10});
            state_in  = ST_XFETCH;
         end
         ST_XFETCH: begin
            tile_in   = rd_data_a_ff;
            attr_in   = rd_data_b_ff;
            rd_addr_a = ADDR_W'({sel_idx_ff[emit_ff], 2'b11});
            state_in  = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.found         = 1'b1;
            rsp_in.slot          = 3'(emit_ff);
            rsp_in.pattern_addr  = pattern_address(tile_ff, attr_ff[7], row,
                                                   cfg.tall, cfg.table_sel);
            rsp_in.x_start       = rd_data_a_ff;
            rsp_in.palette_sel   = PALETTE_BASE + {1'b0, attr_ff[1:0]};
            rsp_in.in_front      = !attr_ff[5];
            rsp_in.mirror_h      = attr_ff[6];
            rsp_in.zero_possible = zero_ff;
            rsp_in.overflow      = over_ff;
            rsp_in.last          = (CNT_W'(emit_ff) + 1'b1) == count_ff;
            if (rsp_in.last) begin
               state_in = ST_IDLE;
            end else begin
               // overlap: issue the next sprite's tile and attribute reads
               emit_in   = next_emit;
               rd_addr_a = ADDR_W'({sel_idx_ff[next_emit], 2'b01});
               rd_addr_b = ADDR_W'({sel_idx_ff[next_emit], 2'b10});
               state_in  = ST_XFETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= store[rd_addr_a];
      rd_data_b_ff <= store[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         ptr_ff        <= '0;
         look_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         ptr_ff        <= ptr_in;
         look_valid_ff <= look_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      line_ff     <= line_in;
      scan_idx_ff <= scan_idx_in;
      look_idx_ff <= look_idx_in;
      count_ff    <= count_in;
      over_ff     <= over_in;
      zero_ff     <= zero_in;
      emit_ff     <= emit_in;
      tile_ff     <= tile_in;
      attr_ff     <= attr_in;
      rsp_ff      <= rsp_in;
      if (take) begin
         sel_idx_ff[count_ff[SLOT_W-1:0]] <= look_idx_ff;
         sel_row_ff[count_ff[SLOT_W-1:0]] <= diff[3:0];
      end
   end

   assign status.clearing  = (state_ff == ST_CLEAR);
   assign status.rsp_valid = rsp_valid_ff;
   assign status.rsp       = rsp_ff;

endmodule

// File: rtl/core/sprite_evaluation_pattern_address.sv
// Top level of sprite evaluation with pattern address generation.
//
//   channel   handshake              carries
//   request   start / busy           req_kind, req_data_byte, req_line_number
//   result    rsp_strobe (1 cycle)   rsp_found ... rsp_last
//   control   csr_valid / csr_ready  csr_index, csr_data
//
// Pointer set and byte write are each applied in the idle state as they leave the queue.
// An evaluation scans the table, reading one entry's y byte per cycle; then each
// selected sprite reads tile and attribute over the two read ports, then x.
// After reset the store is cleared one byte per cycle, all 256 bytes, with busy high.
// Results go out as single-cycle strobes; a four-deep queue holds requests meanwhile.
module sprite_evaluation_pattern_address import sepa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_kind,
   input  logic [7:0]             req_data_byte,
   input  logic [7:0]             req_line_number,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic [2:0]             rsp_slot,
   output logic [12:0]            rsp_pattern_addr,
   output logic [7:0]             rsp_x_start,
   output logic [2:0]             rsp_palette_sel,
   output logic                   rsp_in_front,
   output logic                   rsp_mirror_h,
   output logic                   rsp_zero_possible,
   output logic                   rsp_overflow,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type         cfg_ff, cfg_in;
   back_status_type back_status;
   logic            push, q_pop, q_empty;
   cmd_type         push_cmd, q_cmd;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TALL_SPRITES: cfg_in.tall      = csr_data[0];
            CSR_TABLE_SELECT: cfg_in.table_sel = csr_data[0];
            default:          cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sepa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_line_number (req_line_number),
      .clearing        (back_status.clearing),
      .q_count         (q_count),
      .busy            (busy),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   sepa_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty),
      .count    (q_count)
   );

   sepa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .status  (back_status)
   );

   assign rsp_strobe        = back_status.rsp_valid;
   assign rsp_found         = back_status.rsp.found;
   assign rsp_slot          = back_status.rsp.slot;
   assign rsp_pattern_addr  = back_status.rsp.pattern_addr;
   assign rsp_x_start       = back_status.rsp.x_start;
   assign rsp_palette_sel   = back_status.rsp.palette_sel;
   assign rsp_in_front      = back_status.rsp.in_front;
   assign rsp_mirror_h      = back_status.rsp.mirror_h;
   assign rsp_zero_possible = back_status.rsp.zero_possible;
   assign rsp_overflow      = back_status.rsp.overflow;
   assign rsp_last          = back_status.rsp.last;

   a_no_rsp_while_clearing : assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !rsp_strobe)
      else $error("result strobe during store clear");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overrun");

   a_empty_line_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_last && rsp_palette_sel == PALETTE_BASE))
      else $error("empty-line beat malformed");

   a_no_pop_when_busy_engine : assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_strobe)
      else $error("result strobe right after a queue pop");

endmodule
